// ===== src/b64dec_pkg.sv =====
// Shared types, constants and the character classifier for the base64 stream decoder.
// No dependencies.
package b64dec_pkg;

    localparam int SYM_W   = 8;
    localparam int SEXT_W  = 6;
    localparam int ACC_W   = 12;
    localparam int PEND_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [SEXT_W-1:0] LOWER_BASE = SEXT_W'(26);
    localparam logic [SEXT_W-1:0] DIGIT_BASE = SEXT_W'(52);
    localparam logic [SEXT_W-1:0] PLUS_CODE  = SEXT_W'(62);
    localparam logic [SEXT_W-1:0] SLASH_CODE = SEXT_W'(63);

    typedef enum logic [1:0] {
        CLS_SKIP,
        CLS_SEXTET,
        CLS_PAD
    } sym_class_t;

    typedef struct packed {
        sym_class_t        cls;
        logic [SEXT_W-1:0] sextet;
        logic              last;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    function automatic q_entry_t classify(input logic [SYM_W-1:0] c, input logic last);
        q_entry_t e;
        e.cls    = CLS_SKIP;
        e.sextet = '0;
        e.last   = last;
        if (c >= SYM_W'("A") && c <= SYM_W'("Z"))
        begin
            e.cls    = CLS_SEXTET;
            e.sextet = SEXT_W'(c - SYM_W'("A"));
        end
        else if (c >= SYM_W'("a") && c <= SYM_W'("z"))
        begin
            e.cls    = CLS_SEXTET;
            e.sextet = SEXT_W'(c - SYM_W'("a")) + LOWER_BASE;
        end
        else if (c >= SYM_W'("0") && c <= SYM_W'("9"))
        begin
            e.cls    = CLS_SEXTET;
            e.sextet = SEXT_W'(c - SYM_W'("0")) + DIGIT_BASE;
        end
        else if (c == SYM_W'("+"))
        begin
            e.cls    = CLS_SEXTET;
            e.sextet = PLUS_CODE;
        end
        else if (c == SYM_W'("/"))
        begin
            e.cls    = CLS_SEXTET;
            e.sextet = SLASH_CODE;
        end
        else if (c == SYM_W'("="))
        begin
            e.cls = CLS_PAD;
        end
        return e;
    endfunction

endpackage

// ===== src/b64dec_front.sv =====
// Front end: accepts characters, classifies them and pushes work into the queue.
// Depends on b64dec_pkg.
module b64dec_front (
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [b64dec_pkg::SYM_W-1:0]  symbol,
    input  logic                          text_end,
    input  logic                          q_full,
    output logic                          q_wr,
    output b64dec_pkg::q_entry_t          q_wdata
);

    b64dec_pkg::q_entry_t cls_entry;

    always_comb
    begin
        cls_entry = b64dec_pkg::classify(symbol, text_end);
        in_stall  = q_full;
        q_wdata   = cls_entry;
        // drop skipped characters that do not close the text
        q_wr      = in_valid && !q_full &&
                    !(cls_entry.cls == b64dec_pkg::CLS_SKIP && !text_end);
    end

endmodule

// ===== src/b64dec_queue.sv =====
// Short FIFO between the classifier and the decode back end.
// Depends on b64dec_pkg.
module b64dec_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr,
    input  b64dec_pkg::q_entry_t wdata,
    output logic                 full,
    input  logic                 rd,
    output b64dec_pkg::q_head_t  head
);

    b64dec_pkg::q_entry_t                 mem_reg [b64dec_pkg::QDEPTH];
    logic [b64dec_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [b64dec_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [b64dec_pkg::QCNT_W-1:0]        cnt_reg, cnt_next;
    logic                                 do_rd;

    always_comb
    begin
        full        = (cnt_reg == b64dec_pkg::QCNT_W'(b64dec_pkg::QDEPTH));
        head.valid  = (cnt_reg != '0);
        head.entry  = mem_reg[rd_ptr_reg];
        do_rd       = rd && head.valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == b64dec_pkg::QPTR_W'(b64dec_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == b64dec_pkg::QPTR_W'(b64dec_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + b64dec_pkg::QCNT_W'(wr) - b64dec_pkg::QCNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== src/b64dec_back.sv =====
// Back end: bit accumulator, byte extraction and the output register.
// Depends on b64dec_pkg.
module b64dec_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  b64dec_pkg::q_head_t            head,
    output logic                           rd,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [b64dec_pkg::BYTE_W-1:0]  data_byte,
    output logic                           byte_valid,
    output logic                           done_res
);

    logic [b64dec_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [b64dec_pkg::PEND_W-1:0] pend_reg, pend_next;
    logic                          stopped_reg, stopped_next;
    logic                          oval_reg, oval_next;
    logic [b64dec_pkg::BYTE_W-1:0] obyte_reg, obyte_next;
    logic                          obv_reg, obv_next;
    logic                          odone_reg, odone_next;

    logic [b64dec_pkg::ACC_W-1:0]  acc_shift;
    logic [b64dec_pkg::PEND_W:0]   pend_sum;
    logic                          have;
    logic [b64dec_pkg::BYTE_W-1:0] byte_val;

    always_comb
    begin
        rd           = !oval_reg || !out_stall;
        acc_next     = acc_reg;
        pend_next    = pend_reg;
        stopped_next = stopped_reg;
        oval_next    = oval_reg && out_stall;
        obyte_next   = obyte_reg;
        obv_next     = obv_reg;
        odone_next   = odone_reg;
        have         = 1'b0;
        byte_val     = '0;
        acc_shift    = b64dec_pkg::ACC_W'({acc_reg, head.entry.sextet});
        pend_sum     = {1'b0, pend_reg} + (b64dec_pkg::PEND_W + 1)'(6);

        if (rd && head.valid)
        begin
            if (!stopped_reg)
            begin
                if (head.entry.cls == b64dec_pkg::CLS_PAD)
                begin
                    stopped_next = 1'b1;
                end
                else if (head.entry.cls == b64dec_pkg::CLS_SEXTET)
                begin
                    acc_next  = acc_shift;
                    pend_next = pend_sum[b64dec_pkg::PEND_W-1:0];
                    if (pend_sum[b64dec_pkg::PEND_W])
                    begin
                        have     = 1'b1;
                        byte_val = b64dec_pkg::BYTE_W'(acc_shift >> pend_sum[b64dec_pkg::PEND_W-1:0]);
                    end
                end
            end
            if (have || head.entry.last)
            begin
                oval_next  = 1'b1;
                obyte_next = byte_val;
                obv_next   = have;
                odone_next = head.entry.last;
            end
            if (head.entry.last)
            begin
                acc_next     = '0;
                pend_next    = '0;
                stopped_next = 1'b0;
            end
        end

        out_valid  = oval_reg;
        data_byte  = obyte_reg;
        byte_valid = obv_reg;
        done_res   = odone_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            pend_reg    <= '0;
            stopped_reg <= 1'b0;
            oval_reg    <= 1'b0;
        end
        else
        begin
            acc_reg     <= acc_next;
            pend_reg    <= pend_next;
            stopped_reg <= stopped_next;
            oval_reg    <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obyte_reg <= obyte_next;
        obv_reg   <= obv_next;
        odone_reg <= odone_next;
    end

endmodule

// ===== src/base64_stream_decoder.sv =====
// A character's entry is written into the queue, and its result is then loaded into
// the output register, from which the receiver takes it.
// Throughput: one character per cycle while out_stall is low; the back end's
// accumulator update sets that figure and a two-entry queue absorbs output stalls.
// Reset (rst_n low, asynchronous) empties the queue and output register and
// clears the accumulator, pending count and stop flag.
module base64_stream_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [b64dec_pkg::SYM_W-1:0]   symbol,
    input  logic                           text_end,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [b64dec_pkg::BYTE_W-1:0]  data_byte,
    output logic                           byte_valid,
    output logic                           done_res
);

    logic                 q_full;
    logic                 q_wr;
    logic                 q_rd;
    b64dec_pkg::q_entry_t q_wdata;
    b64dec_pkg::q_head_t  q_head;

    b64dec_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .symbol   (symbol),
        .text_end (text_end),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .q_wdata  (q_wdata)
    );

    b64dec_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_rd),
        .head  (q_head)
    );

    b64dec_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .rd         (q_rd),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .done_res   (done_res)
    );

endmodule
